// ----- sv/assert_macros.svh -----
// assertion macros shared by the checker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock out of reset
`define SMLC_ASSERT_COMB(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock out of reset
`define SMLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/smlc_pkg.sv -----
// types and constants of the set-point motion limit checker
`timescale 1ns / 1ps

package smlc_pkg;

    // fixed field widths
    localparam int AXIS_W  = 4;
    localparam int POS_W   = 32;
    localparam int LIM_W   = 31;
    localparam int DIFF_W  = 33;
    localparam int JF_W    = 16;
    localparam int WARM_W  = 2;

    // defaults and reset values
    localparam int AXIS_COUNT_DEF = 9;
    localparam logic [JF_W-1:0]   JERK_FACTOR_RST = 16'd1280;
    localparam logic [WARM_W-1:0] WARM_VEL  = 2'd1;
    localparam logic [WARM_W-1:0] WARM_ACC  = 2'd2;
    localparam logic [WARM_W-1:0] WARM_JERK = 2'd3;

    // request commands
    typedef enum logic [1:0] {
        CMD_SETPOINT    = 2'd0,
        CMD_QUICK_STOP  = 2'd1,
        CMD_RESET_HIST  = 2'd2,
        CMD_LOAD_LIMITS = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ACC_JERK = 3'd1,
        ST_VEL      = 3'd2,
        ST_HAND     = 3'd3,
        ST_STOPPED  = 3'd4
    } t_status;

    // input request
    typedef struct packed {
        t_cmd                    command;
        logic [AXIS_W-1:0]       axis_index;
        logic signed [POS_W-1:0] position;
        logic [LIM_W-1:0]        vel_limit;
        logic [LIM_W-1:0]        acc_limit;
        logic                    hand_mode;
        logic                    last_axis;
    } t_in_item;

    // result
    typedef struct packed {
        t_status           status;
        logic [AXIS_W-1:0] failing_axis;
        logic              stop_entered;
    } t_out_item;

    // one history entry of one axis
    typedef struct packed {
        logic signed [POS_W-1:0]  pos;
        logic signed [DIFF_W-1:0] vel;
        logic signed [DIFF_W-1:0] acc;
    } t_hist_entry;

    // history write port
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [AXIS_W-1:0] axis;
        t_hist_entry       data;
    } t_hist_wr;

    // control fields carried down the pipeline
    typedef struct packed {
        t_cmd              cmd;
        logic [AXIS_W-1:0] axis;
        logic              in_rng;
        logic              hand;
        logic              last;
    } t_ctl;

endpackage

// ----- sv/smlc_hist_ram.sv -----
// two-bank history memory with registered read and write forwarding
`timescale 1ns / 1ps

module smlc_hist_ram #(
    parameter int AXIS_COUNT = smlc_pkg::AXIS_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [smlc_pkg::AXIS_W-1:0]     i_rd_axis,
    input  smlc_pkg::t_hist_wr              i_wr,
    output smlc_pkg::t_hist_entry           o_rd0,
    output smlc_pkg::t_hist_entry           o_rd1
);
    import smlc_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    t_hist_entry r_mem0 [AXIS_COUNT];
    t_hist_entry r_mem1 [AXIS_COUNT];
    t_hist_entry r_rd0;
    t_hist_entry r_rd1;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          fwd0;
    logic          fwd1;

    assign rd_addr = i_rd_axis[AW-1:0];
    assign wr_addr = i_wr.axis[AW-1:0];
    assign fwd0    = i_wr.en && !i_wr.bank && (i_wr.axis == i_rd_axis);
    assign fwd1    = i_wr.en &&  i_wr.bank && (i_wr.axis == i_rd_axis);

    // bank writes
    always_ff @(posedge i_clk) begin
        if (i_wr.en && !i_wr.bank) begin
            r_mem0[wr_addr] <= i_wr.data;
        end
        if (i_wr.en && i_wr.bank) begin
            r_mem1[wr_addr] <= i_wr.data;
        end
    end

    // registered reads, a same-edge write to the entry is passed through
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd0 <= fwd0 ? i_wr.data : r_mem0[rd_addr];
            r_rd1 <= fwd1 ? i_wr.data : r_mem1[rd_addr];
        end
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

    `SMLC_ASSERT_NEXT(a_fwd_bank0, i_rd_en && fwd0, o_rd0 == $past(i_wr.data), "bank 0 forward lost")
    `SMLC_ASSERT_NEXT(a_fwd_bank1, i_rd_en && fwd1, o_rd1 == $past(i_wr.data), "bank 1 forward lost")
    `SMLC_ASSERT_COMB(a_wr_range, i_wr.en, i_wr.axis < AXIS_COUNT, "history write beyond depth")

endmodule

// ----- sv/setpoint_motion_limit_checker.sv -----
// top level of the set-point motion limit checker
`timescale 1ns / 1ps

// Set-point motion limit checker. Requests carry one axis each; a set-point
// with last_axis closes a frame and gives one result, registered as it leaves
// the last stage. Velocity, acceleration and jerk are formed against a
// per-axis history held in two RAM banks (committed and next frame, AXIS_COUNT
// entries each, registered read) through a four-stage pipeline: history read,
// velocity, acceleration, jerk and verdict. Within a frame the block takes one
// request per clock unless a waiting result stalls it. A frame-closing
// set-point or a history reset holds off the next request until it reaches the
// last stage; quick stop and limit loads flow at full rate. History entries
// carry valid bits cleared by reset and by the history reset command, so no
// clearing pass is needed. Configuration writes complete at once.
module setpoint_motion_limit_checker #(
    parameter int AXIS_COUNT = smlc_pkg::AXIS_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  smlc_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output smlc_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [smlc_pkg::JF_W-1:0]      i_cfg_data
);
    import smlc_pkg::*;

    `include "assert_macros.svh"

    localparam int AW      = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam int SUM_W   = DIFF_W + 1;
    localparam int CMP_W   = DIFF_W + 3;
    localparam int PROD_W  = LIM_W + JF_W;
    localparam logic [AXIS_W:0] AXIS_LIMIT = (AXIS_W+1)'(AXIS_COUNT);

    // saturate a 34-bit difference to signed 33 bits
    function automatic logic signed [DIFF_W-1:0] sat33(input logic signed [SUM_W-1:0] d);
        logic signed [DIFF_W-1:0] s;
        if (d[SUM_W-1] != d[SUM_W-2]) begin
            s = d[SUM_W-1] ? {1'b1, {(DIFF_W-1){1'b0}}} : {1'b0, {(DIFF_W-1){1'b1}}};
        end else begin
            s = d[DIFF_W-1:0];
        end
        return s;
    endfunction

    // magnitude of a signed 33-bit value
    function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] m;
        m = v[DIFF_W-1] ? (DIFF_W'(0) - DIFF_W'(v)) : DIFF_W'(v);
        return m;
    endfunction

    // frame boundary: nothing may be read behind it until it settles
    function automatic logic is_barrier(input t_ctl c);
        return ((c.cmd == CMD_SETPOINT) && c.last) || (c.cmd == CMD_RESET_HIST);
    endfunction

    // frame and control state
    logic                  r_active_bank, n_active_bank;
    logic [WARM_W-1:0]     r_warm, n_warm;
    logic                  r_stopped, n_stopped;
    logic                  r_qs, n_qs;
    logic                  r_ferr_v, n_ferr_v;
    t_status               r_ferr_code, n_ferr_code;
    logic [AXIS_W-1:0]     r_ferr_axis, n_ferr_axis;
    logic [AXIS_COUNT-1:0] r_valid0, n_valid0;
    logic [AXIS_COUNT-1:0] r_valid1, n_valid1;
    logic [JF_W-1:0]       r_jf;

    // limit table
    logic [LIM_W-1:0] r_lim_vel [AXIS_COUNT];
    logic [LIM_W-1:0] r_lim_acc [AXIS_COUNT];

    // pipeline valids and control
    logic r_v1, r_v2, r_v3, r_v4;
    t_ctl r_c1, r_c2, r_c3, r_c4;
    t_ctl in_ctl;

    // stage payloads
    logic signed [POS_W-1:0]  r_s1_pos, r_s2_pos, r_s3_pos, r_s4_pos;
    logic [LIM_W-1:0]         r_s1_vl, r_s1_al, r_s2_vl, r_s2_al, r_s3_al;
    logic signed [DIFF_W-1:0] r_s2_vel, r_s3_vel, r_s4_vel;
    logic signed [DIFF_W-1:0] r_s2_pv, r_s2_pa, r_s3_pa;
    logic signed [DIFF_W-1:0] r_s3_acc, r_s4_acc, r_s4_jerk;
    logic [PROD_W-1:0]        r_s3_prod, r_s4_prod;
    logic                     r_s3_vel_over, r_s3_hand_v;
    logic                     r_s4_vel_over, r_s4_hand_v, r_s4_acc_over, r_s4_hand_a;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    // handshake and hazard control
    logic adv;
    logic in_accept;
    logic bar_in_flight;
    logic out_load;
    t_out_item res;

    // history memory ports
    t_hist_wr    hist_wr;
    t_hist_entry rd0, rd1;

    // stage combinational values
    t_hist_entry              hist_sel;
    logic                     hist_vld;
    logic signed [POS_W-1:0]  prev_pos;
    logic signed [DIFF_W-1:0] prev_vel, prev_acc;
    logic signed [DIFF_W-1:0] vel1, acc2, jerk3;
    logic [DIFF_W-1:0]        mv2, ma3, mj4;
    logic [CMP_W-1:0]         mv5, vl6, vl3, ma_ext, al5, al2;
    logic                     jerk_over4;
    t_status                  code4;
    logic                     chk4;

    // stall only when a result would overwrite one still waiting
    assign adv = !(r_v4 && (r_c4.cmd == CMD_SETPOINT) && r_c4.last &&
                   r_out_valid && !i_out_ready);
    assign bar_in_flight = (r_v1 && is_barrier(r_c1)) || (r_v2 && is_barrier(r_c2)) ||
                           (r_v3 && is_barrier(r_c3));
    assign o_in_ready  = adv && !bar_in_flight;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign in_ctl.cmd    = i_in_data.command;
    assign in_ctl.axis   = i_in_data.axis_index;
    assign in_ctl.in_rng = {1'b0, i_in_data.axis_index} < AXIS_LIMIT;
    assign in_ctl.hand   = i_in_data.hand_mode;
    assign in_ctl.last   = i_in_data.last_axis;

    // history memory, read as a request is taken
    smlc_hist_ram #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_axis (i_in_data.axis_index),
        .i_wr      (hist_wr),
        .o_rd0     (rd0),
        .o_rd1     (rd1)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jf <= JERK_FACTOR_RST;
        end else if (i_cfg_valid) begin
            r_jf <= i_cfg_data;
        end
    end

    // limit table, loaded in request order as the load is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                r_lim_vel[i] <= '0;
                r_lim_acc[i] <= '0;
            end
        end else if (in_accept && (i_in_data.command == CMD_LOAD_LIMITS) && in_ctl.in_rng) begin
            r_lim_vel[i_in_data.axis_index[AW-1:0]] <= i_in_data.vel_limit;
            r_lim_acc[i_in_data.axis_index[AW-1:0]] <= i_in_data.acc_limit;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= in_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: committed history of the axis, velocity
    assign hist_sel = r_active_bank ? rd1 : rd0;
    assign hist_vld = r_active_bank ? r_valid1[r_c1.axis[AW-1:0]] : r_valid0[r_c1.axis[AW-1:0]];
    assign prev_pos = hist_vld ? hist_sel.pos : '0;
    assign prev_vel = hist_vld ? hist_sel.vel : '0;
    assign prev_acc = hist_vld ? hist_sel.acc : '0;
    assign vel1 = (r_warm >= WARM_VEL) ? (DIFF_W'(r_s1_pos) - DIFF_W'(prev_pos)) : '0;

    // stage 2: acceleration, velocity checks, jerk limit product
    assign acc2 = (r_warm >= WARM_ACC) ? sat33(SUM_W'(r_s2_vel) - SUM_W'(r_s2_pv)) : '0;
    assign mv2  = mag33(r_s2_vel);
    assign mv5  = (CMP_W'(mv2) << 2) + CMP_W'(mv2);
    assign vl6  = (CMP_W'(r_s2_vl) << 2) + (CMP_W'(r_s2_vl) << 1);
    assign vl3  = (CMP_W'(r_s2_vl) << 1) + CMP_W'(r_s2_vl);

    // stage 3: jerk, acceleration checks
    assign jerk3  = (r_warm >= WARM_JERK) ? sat33(SUM_W'(r_s3_acc) - SUM_W'(r_s3_pa)) : '0;
    assign ma3    = mag33(r_s3_acc);
    assign ma_ext = CMP_W'(ma3);
    assign al5    = (CMP_W'(r_s3_al) << 2) + CMP_W'(r_s3_al);
    assign al2    = CMP_W'(r_s3_al) << 1;

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1     <= in_ctl;
            r_s1_pos <= i_in_data.position;
            r_s1_vl  <= r_lim_vel[i_in_data.axis_index[AW-1:0]];
            r_s1_al  <= r_lim_acc[i_in_data.axis_index[AW-1:0]];

            r_c2     <= r_c1;
            r_s2_pos <= r_s1_pos;
            r_s2_vel <= vel1;
            r_s2_pv  <= prev_vel;
            r_s2_pa  <= prev_acc;
            r_s2_vl  <= r_s1_vl;
            r_s2_al  <= r_s1_al;

            r_c3          <= r_c2;
            r_s3_pos      <= r_s2_pos;
            r_s3_vel      <= r_s2_vel;
            r_s3_acc      <= acc2;
            r_s3_pa       <= r_s2_pa;
            r_s3_al       <= r_s2_al;
            r_s3_prod     <= PROD_W'(r_s2_al) * PROD_W'(r_jf);
            r_s3_vel_over <= (r_s2_vl != '0) && (mv5 > vl6);
            r_s3_hand_v   <= (r_s2_vl != '0) && (mv5 > vl3);

            r_c4          <= r_c3;
            r_s4_pos      <= r_s3_pos;
            r_s4_vel      <= r_s3_vel;
            r_s4_acc      <= r_s3_acc;
            r_s4_jerk     <= jerk3;
            r_s4_prod     <= r_s3_prod;
            r_s4_vel_over <= r_s3_vel_over;
            r_s4_hand_v   <= r_s3_hand_v;
            r_s4_acc_over <= ma_ext > al5;
            r_s4_hand_a   <= (r_s3_al != '0) && (ma_ext > al2);
        end
    end

    // stage 4: jerk check and verdict
    assign mj4        = mag33(r_s4_jerk);
    assign jerk_over4 = PROD_W'({mj4, 8'h00}) > r_s4_prod;
    always_comb begin
        priority if (r_s4_acc_over || jerk_over4) begin
            code4 = ST_ACC_JERK;
        end else if (r_s4_vel_over) begin
            code4 = ST_VEL;
        end else if (r_c4.hand && (r_s4_hand_v || r_s4_hand_a)) begin
            code4 = ST_HAND;
        end else begin
            code4 = ST_OK;
        end
    end
    assign chk4 = (r_c4.cmd == CMD_SETPOINT) && r_c4.in_rng && !r_stopped && !r_ferr_v;

    // frame state update, history write-back and result
    always_comb begin
        n_active_bank = r_active_bank;
        n_warm        = r_warm;
        n_stopped     = r_stopped;
        n_qs          = r_qs;
        n_ferr_v      = r_ferr_v;
        n_ferr_code   = r_ferr_code;
        n_ferr_axis   = r_ferr_axis;
        n_valid0      = r_valid0;
        n_valid1      = r_valid1;
        hist_wr       = '0;
        hist_wr.bank  = !r_active_bank;
        hist_wr.axis  = r_c4.axis;
        hist_wr.data.pos = r_s4_pos;
        hist_wr.data.vel = r_s4_vel;
        hist_wr.data.acc = r_s4_acc;
        res.status       = ST_OK;
        res.failing_axis = '0;
        res.stop_entered = 1'b0;
        out_load      = 1'b0;
        if (adv && r_v4) begin
            unique case (r_c4.cmd)
                CMD_QUICK_STOP: begin
                    n_qs = 1'b1;
                end
                CMD_RESET_HIST: begin
                    n_active_bank = 1'b0;
                    n_warm        = '0;
                    n_stopped     = 1'b0;
                    n_qs          = 1'b0;
                    n_ferr_v      = 1'b0;
                    n_valid0      = '0;
                    n_valid1      = '0;
                end
                CMD_LOAD_LIMITS: begin
                    n_qs = r_qs;
                end
                CMD_SETPOINT: begin
                    if (chk4) begin
                        if (code4 != ST_OK) begin
                            n_ferr_v    = 1'b1;
                            n_ferr_code = code4;
                            n_ferr_axis = r_c4.axis;
                        end else begin
                            hist_wr.en = 1'b1;
                            if (r_active_bank) begin
                                n_valid0[r_c4.axis[AW-1:0]] = 1'b1;
                            end else begin
                                n_valid1[r_c4.axis[AW-1:0]] = 1'b1;
                            end
                        end
                    end
                    // frame end
                    if (r_c4.last) begin
                        out_load = 1'b1;
                        priority if (r_stopped) begin
                            res.status = ST_STOPPED;
                        end else if (r_qs) begin
                            n_qs             = 1'b0;
                            n_stopped        = 1'b1;
                            res.status       = ST_STOPPED;
                            res.stop_entered = 1'b1;
                        end else if (n_ferr_v) begin
                            n_stopped        = 1'b1;
                            res.status       = n_ferr_code;
                            res.failing_axis = n_ferr_axis;
                            res.stop_entered = 1'b1;
                        end else begin
                            n_active_bank = !r_active_bank;
                            if (r_warm != WARM_JERK) begin
                                n_warm = r_warm + WARM_W'(1);
                            end
                        end
                        n_ferr_v = 1'b0;
                    end
                end
                default: begin
                    n_qs = r_qs;
                end
            endcase
        end
    end

    // control state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bank <= 1'b0;
            r_warm        <= '0;
            r_stopped     <= 1'b0;
            r_qs          <= 1'b0;
            r_ferr_v      <= 1'b0;
            r_ferr_code   <= ST_OK;
            r_ferr_axis   <= '0;
            r_valid0      <= '0;
            r_valid1      <= '0;
        end else begin
            r_active_bank <= n_active_bank;
            r_warm        <= n_warm;
            r_stopped     <= n_stopped;
            r_qs          <= n_qs;
            r_ferr_v      <= n_ferr_v;
            r_ferr_code   <= n_ferr_code;
            r_ferr_axis   <= n_ferr_axis;
            r_valid0      <= n_valid0;
            r_valid1      <= n_valid1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SMLC_ASSERT_COMB(a_wr_inactive, hist_wr.en, hist_wr.bank != r_active_bank, "history write hit the committed bank")
    `SMLC_ASSERT_COMB(a_barrier_hold, bar_in_flight, !in_accept, "request taken behind a frame boundary")
    `SMLC_ASSERT_COMB(a_wr_clean, hist_wr.en, !r_stopped && !r_ferr_v && (code4 == ST_OK), "history stored from a failed or stopped frame")

endmodule
